/* rtl/gji_pkg.sv */
// Package: shared constants for the Gauss-Jordan inverter.
package gji_pkg;
  localparam int unsigned SizeW = 3;
  localparam logic [SizeW-1:0] SizeReset = 3'd6;
endpackage

/* rtl/gji_stream_if.sv */
// Interfaces: valid/ready channels for matrix elements and results.
interface gji_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] elem_value;
  modport source (output valid, output elem_value, input ready);
  modport sink   (input valid, input elem_value, output ready);
endinterface

interface gji_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] inv_value;
  logic        singular;
  logic        last_elem;
  modport source (output valid, output inv_value, output singular, output last_elem,
                  input ready);
  modport sink   (input valid, input inv_value, input singular, input last_elem,
                  output ready);
endinterface

/* rtl/gji_div.sv */
// Divider: restoring 64/32 unsigned division, one quotient bit a cycle.
module gji_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] sh;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    sh = {rem_q[31:0], quo_q[63]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q}; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = sh; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quo_o  = quo_d;
endmodule

/* rtl/gji_mul.sv */
// Multiplier: registered Q-format product with rounding and saturation.
module gji_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);
  logic signed [63:0] prod_q;
  logic        [63:0] m, r;
  logic               neg;
  logic signed [64:0] v;

  always_ff @(posedge clk_i) prod_q <= $signed(a_i) * $signed(b_i);

  always_comb begin
    neg = prod_q[63];
    m   = neg ? (64'd0 - prod_q) : prod_q;
    r   = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    v   = neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (v > 65'sh7FFFFFFF) p_o = 32'h7FFFFFFF;
    else if (v < -65'sh80000000) p_o = 32'h80000000;
    else p_o = v[31:0];
  end
endmodule

/* rtl/gauss_jordan_matrix_inverse.sv */
// Top level: Gauss-Jordan matrix inverter with partial pivoting.
//
// Usage: elements of an n-by-n matrix arrive row-major on in_req, one signed
// fixed-point word per request. n comes from size_q, set by cfg_we_i (0 reads as 1,
// above MAX_DIM as MAX_DIM) and is sampled on each request. When n*n elements are
// in, the block inverts in place and stops taking requests until the last
// result has gone.
// Results leave on out_req: n*n words, last_elem on the final one, or one
// word flagged singular if a pivot is zero.
// Sequence: per column a pivot scan, a row swap when needed, a reciprocal on
// the radix-2 divider, a row scale and elimination of every other row, all
// on one shared multiplier with a store of one read and one write port.
// Column unswaps then follow, and then the results leave.
// Stall: a stalled result holds on the output register; the sequencer waits.
// Reset: control state clears, size returns to 6; the store is not cleared.
module gauss_jordan_matrix_inverse
  import gji_pkg::*;
#(
  parameter int unsigned MAX_DIM   = 6,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  gji_in_if.sink           in_req,
  gji_out_if.source        out_req
);
  localparam int unsigned Cells = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned CW    = $clog2(Cells + 1);

  localparam logic [4:0] S_LOAD = 5'd0,  S_PV_RD = 5'd1,  S_PV_CK = 5'd2,
                         S_PV_T = 5'd3,  S_SW_RA = 5'd4,  S_SW_RB = 5'd5,
                         S_SW_W = 5'd6,  S_DIV   = 5'd7,  S_SC_RD = 5'd8,
                         S_SC_M = 5'd9,  S_SC_W  = 5'd10, S_EL_F  = 5'd11,
                         S_EL_RK = 5'd12, S_EL_M = 5'd13, S_EL_RI = 5'd14,
                         S_EL_W = 5'd15, S_UN_RA = 5'd16, S_UN_RB = 5'd17,
                         S_UN_W = 5'd18, S_OUT_RD = 5'd19, S_OUT_W = 5'd20,
                         S_SING = 5'd21, S_SC_FX = 5'd22, S_SW_WK = 5'd23,
                         S_UN_WK = 5'd24;

  logic [SizeW-1:0] size_q;
  logic [4:0]       st_q;
  logic [5:0]       ld_q;
  logic [DW-1:0]    n_q, k_q, i_q, j_q, piv_q, uk_q;
  logic [DW-1:0]    swp_q [MAX_DIM];
  logic [31:0]      mem [Cells];
  logic [31:0]      rd_q, ta_q, recip_q, f_q, prod_q;
  logic [32:0]      best_q;
  logic [AW-1:0]    ra, wa;
  logic [31:0]      wd;
  logic             we;
  logic [CW-1:0]    oc_q;
  logic [DW-1:0]    n_now;
  logic [31:0]      mul_a, mul_b, mul_p;
  logic             dv_start, dv_done;
  logic [63:0]      dv_quo;
  logic [31:0]      piv_mag;
  logic             piv_neg_q;
  logic [32:0]      cur_mag;
  logic [32:0]      diff;
  logic [DW-1:0]    up;

  function automatic logic [AW-1:0] adr(input logic [DW-1:0] r, input logic [DW-1:0] c,
                                        input logic [DW-1:0] n);
    logic [2*DW:0] t;
    t = r * n + c;
    return t[AW-1:0];
  endfunction

  always_comb begin
    if (size_q == '0) n_now = DW'(1);
    else if (32'(size_q) > MAX_DIM) n_now = DW'(MAX_DIM);
    else n_now = DW'(size_q);
  end

  gji_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  assign piv_mag  = rd_q[31] ? (32'd0 - rd_q) : rd_q;
  assign dv_start = (st_q == S_SC_FX);
  gji_div u_div (.clk_i, .rst_ni, .start_i(dv_start),
                 .num_i((64'd1 << (2 * FRAC_BITS)) + {33'd0, piv_mag[31:1]}),
                 .den_i(piv_mag), .done_o(dv_done), .quo_o(dv_quo));

  assign cur_mag = rd_q[31] ? (33'd0 - {1'b1, rd_q}) : {1'b0, rd_q};
  // the pivot column of an eliminated row starts from zero
  assign diff    = ((j_q == k_q) ? 33'd0 : {rd_q[31], rd_q}) - {prod_q[31], prod_q};
  assign up      = (32'(swp_q[uk_q]) >= 32'(n_q)) ? n_q - DW'(1) : swp_q[uk_q];

  // operand selection for the shared multiplier; the pivot word scales as 1.0
  always_comb begin
    mul_a = (st_q == S_SC_M && j_q == k_q) ? (32'd1 << FRAC_BITS) : rd_q;
    mul_b = (st_q == S_SC_M) ? recip_q : f_q;
  end

  // store address and write data
  always_comb begin
    ra = '0; wa = '0; wd = rd_q; we = 1'b0;
    case (st_q)
      S_LOAD:  begin
        wa = ld_q[AW-1:0]; wd = in_req.elem_value;
        we = in_req.valid && in_req.ready && (32'(ld_q) < Cells);
      end
      S_PV_RD: ra = adr(i_q, k_q, n_q);
      S_SW_RA: ra = adr(k_q, j_q, n_q);
      S_SW_RB: ra = adr(piv_q, j_q, n_q);
      S_SW_W:  begin wa = adr(piv_q, j_q, n_q); wd = ta_q; we = 1'b1; end
      S_SW_WK: begin wa = adr(k_q, j_q, n_q); wd = ta_q; we = 1'b1; end
      S_DIV:   ra = adr(k_q, k_q, n_q);
      S_SC_RD: ra = adr(k_q, j_q, n_q);
      S_SC_W:  begin wa = adr(k_q, j_q, n_q); wd = mul_p; we = 1'b1; end
      S_EL_F:  ra = adr(i_q, k_q, n_q);
      S_EL_RK: ra = adr(k_q, j_q, n_q);
      S_EL_RI: ra = adr(i_q, j_q, n_q);
      S_EL_W:  begin
        wa = adr(i_q, j_q, n_q); we = 1'b1;
        if (diff[32] != diff[31]) wd = diff[32] ? 32'h80000000 : 32'h7FFFFFFF;
        else wd = diff[31:0];
      end
      S_UN_RA: ra = adr(i_q, uk_q, n_q);
      S_UN_RB: ra = adr(i_q, up, n_q);
      S_UN_W:  begin wa = adr(i_q, up, n_q); wd = ta_q; we = 1'b1; end
      S_UN_WK: begin wa = adr(i_q, uk_q, n_q); wd = ta_q; we = 1'b1; end
      S_OUT_RD: ra = oc_q[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // second write ports are folded into follow-up cycles below
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset; st_q <= S_LOAD; ld_q <= '0; oc_q <= '0;
      n_q <= '0; k_q <= '0; i_q <= '0; j_q <= '0; piv_q <= '0; uk_q <= '0;
      out_req.valid <= 1'b0;
    end else begin
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (out_req.valid && out_req.ready) out_req.valid <= 1'b0;
      case (st_q)
        S_LOAD: if (in_req.valid && in_req.ready) begin
          if (32'(ld_q + 6'd1) >= 32'(n_now) * 32'(n_now)) begin
            ld_q <= '0; n_q <= n_now; k_q <= '0; i_q <= '0; st_q <= S_PV_RD;
          end else ld_q <= ld_q + 6'd1;
        end
        S_PV_RD: st_q <= S_PV_CK;
        S_PV_CK: begin
          if (i_q == k_q || cur_mag >= best_q) begin
            best_q <= cur_mag; piv_q <= i_q;
          end
          if (i_q == n_q - DW'(1)) st_q <= S_PV_T;
          else begin i_q <= i_q + DW'(1); st_q <= S_PV_RD; end
        end
        S_PV_T: begin
          swp_q[k_q] <= piv_q; j_q <= '0;
          if (best_q == '0) st_q <= S_SING;
          else if (piv_q != k_q) st_q <= S_SW_RA;
          else st_q <= S_DIV;
        end
        S_SW_RA: st_q <= S_SW_RB;
        S_SW_RB: begin ta_q <= rd_q; st_q <= S_SW_W; end
        // pivot row word written back into row k on the next cycle
        S_SW_W: begin ta_q <= rd_q; st_q <= S_SW_WK; end
        S_SW_WK: begin
          if (j_q == n_q - DW'(1)) st_q <= S_DIV;
          else begin j_q <= j_q + DW'(1); st_q <= S_SW_RA; end
        end
        S_DIV: st_q <= S_SC_FX;
        S_SC_FX: begin piv_neg_q <= rd_q[31]; st_q <= S_SC_RD; j_q <= '0; end
        S_SC_RD: begin
          if (j_q != '0) st_q <= S_SC_M;
          else if (dv_done) begin
            if (dv_quo >= 64'h80000000) recip_q <= piv_neg_q ? 32'h80000000 : 32'h7FFFFFFF;
            else recip_q <= piv_neg_q ? (32'd0 - dv_quo[31:0]) : dv_quo[31:0];
            st_q <= S_SC_M;
          end
        end
        S_SC_M: st_q <= S_SC_W;
        S_SC_W: begin
          if (j_q == n_q - DW'(1)) begin i_q <= '0; j_q <= '0; st_q <= S_EL_F; end
          else begin j_q <= j_q + DW'(1); st_q <= S_SC_RD; end
        end
        S_EL_F: begin
          if (i_q == k_q) begin
            if (i_q == n_q - DW'(1)) begin
              if (k_q == n_q - DW'(1)) begin uk_q <= k_q; i_q <= '0; st_q <= S_UN_RA; end
              else begin k_q <= k_q + DW'(1); i_q <= k_q + DW'(1); st_q <= S_PV_RD; end
            end else i_q <= i_q + DW'(1);
          end else begin j_q <= '0; st_q <= S_EL_RK; end
        end
        S_EL_RK: begin
          if (j_q == '0) f_q <= rd_q;
          st_q <= S_EL_M;
        end
        S_EL_M: st_q <= S_EL_RI;
        S_EL_RI: begin prod_q <= mul_p; st_q <= S_EL_W; end
        S_EL_W: begin
          ta_q <= rd_q;
          if (j_q == n_q - DW'(1)) begin
            if (i_q == n_q - DW'(1)) begin
              if (k_q == n_q - DW'(1)) begin uk_q <= k_q; i_q <= '0; st_q <= S_UN_RA; end
              else begin k_q <= k_q + DW'(1); i_q <= k_q + DW'(1); st_q <= S_PV_RD; end
            end else begin i_q <= i_q + DW'(1); st_q <= S_EL_F; end
          end else begin j_q <= j_q + DW'(1); st_q <= S_EL_RK; end
        end
        // a column that was never swapped is skipped
        S_UN_RA: begin
          if (up == uk_q) begin
            i_q <= '0;
            if (uk_q == '0) begin oc_q <= '0; st_q <= S_OUT_RD; end
            else uk_q <= uk_q - DW'(1);
          end else st_q <= S_UN_RB;
        end
        S_UN_RB: begin ta_q <= rd_q; st_q <= S_UN_W; end
        S_UN_W: begin ta_q <= rd_q; st_q <= S_UN_WK; end
        S_UN_WK: begin
          if (i_q == n_q - DW'(1)) begin
            i_q <= '0;
            if (uk_q == '0) begin oc_q <= '0; st_q <= S_OUT_RD; end
            else begin uk_q <= uk_q - DW'(1); st_q <= S_UN_RA; end
          end else begin i_q <= i_q + DW'(1); st_q <= S_UN_RA; end
        end
        S_OUT_RD: if (!out_req.valid || out_req.ready) st_q <= S_OUT_W;
        S_OUT_W: begin
          out_req.valid <= 1'b1; out_req.inv_value <= rd_q;
          out_req.singular <= 1'b0;
          out_req.last_elem <= (32'(oc_q) + 1 == 32'(n_q) * 32'(n_q));
          if (32'(oc_q) + 1 == 32'(n_q) * 32'(n_q)) begin oc_q <= '0; st_q <= S_LOAD; end
          else begin oc_q <= oc_q + CW'(1); st_q <= S_OUT_RD; end
        end
        S_SING: if (!out_req.valid) begin
          out_req.valid <= 1'b1; out_req.inv_value <= '0;
          out_req.singular <= 1'b1; out_req.last_elem <= 1'b1; st_q <= S_LOAD;
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end

  assign in_req.ready = (st_q == S_LOAD) && !out_req.valid;
endmodule
